// ===== rtl/assert_macros.svh =====
// assertion macros shared by the look-at matrix rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge out of reset
`define LAV_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("lav assertion failed");
// condition must never be true out of reset
`define LAV_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("lav forbidden condition seen");
`else
`define LAV_ASSERT(lbl, clk, rst_n, prop)
`define LAV_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/lav_pkg.sv =====
// shared constants and types of the look-at matrix block
`default_nettype none
package lav_pkg;
	// result column numbering
	localparam int COL_W = 2;
	typedef logic [COL_W-1:0] col_t;
	localparam col_t COL_FIRST = 2'd0;
	localparam col_t COL_LAST  = 2'd3;
endpackage
`default_nettype wire

// ===== rtl/lav_front.sv =====
// front end: accepts words, forms the forward difference, queues jobs
`default_nettype none
`include "assert_macros.svh"
module lav_front #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [3*COORD_WIDTH-1:0]       in_eye,
	input  logic [3*COORD_WIDTH-1:0]       in_tgt,
	output logic                           q_valid,
	input  logic                           q_take,
	output logic [3*COORD_WIDTH-1:0]       q_eye,
	output logic [2:0]                     q_neg,
	output logic [3*(COORD_WIDTH+1)-1:0]   q_mag
);
	localparam int CW = COORD_WIDTH;
	localparam int EW = 3*CW + 3 + 3*(CW+1);

	logic [EW-1:0]           ent_q [2];
	logic                    wr_q;
	logic                    rd_q;
	logic [1:0]              cnt_q;
	logic [2:0]              neg_c;
	logic [3*(CW+1)-1:0]     mag_c;
	logic signed [CW:0]      diff;
	logic                    push_ok;
	logic                    pop_ok;

	// sign and magnitude of target minus eye per axis
	always_comb begin
		neg_c = '0;
		mag_c = '0;
		diff = '0;
		for (int i = 0; i < 3; i++) begin
			diff = $signed({in_tgt[i*CW+CW-1], in_tgt[i*CW +: CW]})
				- $signed({in_eye[i*CW+CW-1], in_eye[i*CW +: CW]});
			neg_c[i] = diff[CW];
			mag_c[i*(CW+1) +: (CW+1)] = diff[CW] ? (CW+1)'(-diff) : (CW+1)'(diff);
		end
	end

	assign push_ok = push && !full;
	assign pop_ok  = q_take && q_valid;
	assign full    = cnt_q == 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign {q_mag, q_neg, q_eye} = ent_q[rd_q];

	// two-entry job queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push_ok) wr_q <= !wr_q;
			if (pop_ok) rd_q <= !rd_q;
			case ({push_ok, pop_ok})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push_ok) ent_q[wr_q] <= {mag_c, neg_c, in_eye};
	end

	`LAV_NEVER(a_cnt_range, clk, arst_n, cnt_q == 2'd3)
endmodule
`default_nettype wire

// ===== rtl/lav_engine.sv =====
// back end: normalize, cross products and translation on one shared multiplier
`default_nettype none
`include "assert_macros.svh"
module lav_engine #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	output logic                           q_take,
	input  logic [3*COORD_WIDTH-1:0]       q_eye,
	input  logic [2:0]                     q_neg,
	input  logic [3*(COORD_WIDTH+1)-1:0]   q_mag,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic [3*(FRAC_BITS+3)-1:0]     s_flat,
	output logic [3*(FRAC_BITS+3)-1:0]     u_flat,
	output logic [3*(FRAC_BITS+3)-1:0]     f_flat,
	output logic [3*COORD_WIDTH-1:0]       tr_flat
);
	localparam int CW = COORD_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam int VW = FB + 3;
	localparam int MW = (CW + 1 > 33) ? CW + 1 : 33;
	localparam int MA = (VW > 31) ? VW : 31;
	localparam int MB = (CW > MA) ? CW : MA;
	localparam int PW = MA + MB;
	localparam int AW = PW + 3;
	localparam int NW = FB + 31;
	localparam int SQ_ITERS = 32;
	localparam int CNW = $clog2((FB + 1 > SQ_ITERS) ? FB + 1 : SQ_ITERS);
	localparam logic signed [AW-1:0] HALF = {{(AW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
	localparam logic signed [AW-1:0] MAXC = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [AW-1:0] MINC = {{(AW-CW+1){1'b1}}, {(CW-1){1'b0}}};

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_SHIFT = 11'b000_0000_0010,
		ST_MUL   = 11'b000_0000_0100,
		ST_ADD   = 11'b000_0000_1000,
		ST_SQI   = 11'b000_0001_0000,
		ST_SQRT  = 11'b000_0010_0000,
		ST_DIVI  = 11'b000_0100_0000,
		ST_DIV   = 11'b000_1000_0000,
		ST_POST  = 11'b001_0000_0000,
		ST_ROUND = 11'b010_0000_0000,
		ST_DONE  = 11'b100_0000_0000
	} state_t;

	typedef enum logic [3:0] {
		MD_NORMF = 4'b0001,
		MD_NORMS = 4'b0010,
		MD_CROSS = 4'b0100,
		MD_DOT   = 4'b1000
	} mode_t;

	state_t                  state_q;
	mode_t                   mode_q;
	logic [1:0]              ix_q;
	logic [1:0]              vi_q;
	logic [CNW-1:0]          cnt_q;

	logic signed [CW-1:0]    eye_q [3];
	logic                    neg_q [3];
	logic [MW-1:0]           mag_q [3];
	logic signed [VW-1:0]    nv_q [3];
	logic signed [VW-1:0]    f_q [3];
	logic signed [VW-1:0]    s_q [3];
	logic signed [VW-1:0]    u_q [3];
	logic signed [CW-1:0]    tr_q [3];
	logic signed [PW-1:0]    prod_q;
	logic signed [AW-1:0]    acc_q;
	logic [63:0]             sq_n_q;
	logic [63:0]             sq_r_q;
	logic [63:0]             sq_b_q;
	logic [31:0]             len_q;
	logic [30:0]             rem_q;
	logic [FB:0]             lo_q;
	logic [FB:0]             quo_q;

	logic                    any_hi;
	logic                    all_lo;
	logic                    all_zero;
	logic [MW-1:0]           mag_sel;
	logic                    neg_sel;
	logic signed [CW-1:0]    eye_sel;
	logic signed [VW-1:0]    vec_sel;
	logic [1:0]              jx;
	logic [1:0]              kx;
	logic signed [MA-1:0]    op_a;
	logic signed [MB-1:0]    op_b;
	logic                    sub;
	logic [63:0]             sq_rb;
	logic                    sq_ge;
	logic [63:0]             sq_r_nx;
	logic [63:0]             sq_n_nx;
	logic [NW-1:0]           num;
	logic [31:0]             dv_t;
	logic                    dv_ge;
	logic [30:0]             rem_nx;
	logic [FB:0]             quo_nx;
	logic signed [VW-1:0]    q_signed;
	logic signed [AW-1:0]    rsum;
	logic signed [AW-1:0]    rsh;
	logic signed [CW-1:0]    tr_val;
	logic [VW-1:0]           abs0;
	logic [VW-1:0]           abs2;

	function automatic logic signed [VW-1:0] pick3(
		input logic signed [VW-1:0] v0,
		input logic signed [VW-1:0] v1,
		input logic signed [VW-1:0] v2,
		input logic [1:0]           idx
	);
		logic signed [VW-1:0] r;
		case (idx)
			2'd1:    r = v1;
			2'd2:    r = v2;
			default: r = v0;
		endcase
		return r;
	endfunction

	// range checks that steer the normalizing shift
	always_comb begin
		any_hi = 1'b0;
		all_lo = 1'b1;
		all_zero = 1'b1;
		for (int i = 0; i < 3; i++) begin
			any_hi = any_hi | (|mag_q[i][MW-1:30]);
			all_lo = all_lo & ~(|mag_q[i][MW-1:29]);
			all_zero = all_zero & ~(|mag_q[i]);
		end
	end

	// element selects by component index
	always_comb begin
		case (ix_q)
			2'd1: begin
				mag_sel = mag_q[1];
				neg_sel = neg_q[1];
				eye_sel = eye_q[1];
				jx = 2'd2;
				kx = 2'd0;
			end
			2'd2: begin
				mag_sel = mag_q[2];
				neg_sel = neg_q[2];
				eye_sel = eye_q[2];
				jx = 2'd0;
				kx = 2'd1;
			end
			default: begin
				mag_sel = mag_q[0];
				neg_sel = neg_q[0];
				eye_sel = eye_q[0];
				jx = 2'd1;
				kx = 2'd2;
			end
		endcase
		case (vi_q)
			2'd1:    vec_sel = pick3(u_q[0], u_q[1], u_q[2], ix_q);
			2'd2:    vec_sel = pick3(f_q[0], f_q[1], f_q[2], ix_q);
			default: vec_sel = pick3(s_q[0], s_q[1], s_q[2], ix_q);
		endcase
	end

	// shared multiplier operands
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (mode_q) inside
			MD_NORMF, MD_NORMS: begin
				op_a = $signed(MA'(mag_sel[29:0]));
				op_b = $signed(MB'(mag_sel[29:0]));
			end
			MD_CROSS: begin
				if (vi_q == 2'd0) begin
					op_a = MA'(pick3(s_q[0], s_q[1], s_q[2], jx));
					op_b = MB'(pick3(f_q[0], f_q[1], f_q[2], kx));
				end else begin
					op_a = MA'(pick3(s_q[0], s_q[1], s_q[2], kx));
					op_b = MB'(pick3(f_q[0], f_q[1], f_q[2], jx));
				end
			end
			MD_DOT: begin
				op_a = MA'(vec_sel);
				op_b = MB'(eye_sel);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign sub = (mode_q == MD_CROSS && vi_q == 2'd1) || (mode_q == MD_DOT && vi_q != 2'd2);

	// one square root step
	always_comb begin
		sq_rb = sq_r_q + sq_b_q;
		sq_ge = sq_n_q >= sq_rb;
		sq_r_nx = sq_ge ? (sq_r_q >> 1) + sq_b_q : sq_r_q >> 1;
		sq_n_nx = sq_ge ? sq_n_q - sq_rb : sq_n_q;
	end

	// one restoring division step
	always_comb begin
		num = NW'({mag_sel[29:0], {FB{1'b0}}}) + NW'(len_q[31:1]);
		dv_t = {rem_q, lo_q[FB]};
		dv_ge = dv_t >= len_q;
		rem_nx = dv_ge ? 31'(dv_t - len_q) : dv_t[30:0];
		quo_nx = {quo_q[FB-1:0], dv_ge};
		q_signed = neg_sel ? -$signed({2'b00, quo_nx}) : $signed({2'b00, quo_nx});
	end

	// rounding and saturation of the accumulator, and magnitudes for the side direction
	always_comb begin
		rsum = acc_q + HALF;
		rsh = rsum >>> FB;
		if (rsh > MAXC) tr_val = {1'b0, {(CW-1){1'b1}}};
		else if (rsh < MINC) tr_val = {1'b1, {(CW-1){1'b0}}};
		else tr_val = rsh[CW-1:0];
		abs0 = nv_q[2][VW-1] ? VW'(-nv_q[2]) : VW'(nv_q[2]);
		abs2 = nv_q[0][VW-1] ? VW'(-nv_q[0]) : VW'(nv_q[0]);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MD_NORMF;
			ix_q    <= 2'd0;
			vi_q    <= 2'd0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						mode_q  <= MD_NORMF;
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (all_zero) state_q <= ST_POST;
					else if (!any_hi && !all_lo) begin
						ix_q    <= 2'd0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: begin
					unique case (mode_q) inside
						MD_NORMF, MD_NORMS: begin
							if (ix_q == 2'd2) state_q <= ST_SQI;
							else begin
								ix_q    <= ix_q + 2'd1;
								state_q <= ST_MUL;
							end
						end
						MD_CROSS: begin
							if (vi_q == 2'd0) begin
								vi_q    <= 2'd1;
								state_q <= ST_MUL;
							end else state_q <= ST_ROUND;
						end
						default: begin
							if (ix_q == 2'd2) state_q <= ST_ROUND;
							else begin
								ix_q    <= ix_q + 2'd1;
								state_q <= ST_MUL;
							end
						end
					endcase
				end
				ST_SQI: begin
					cnt_q   <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (cnt_q == CNW'(SQ_ITERS - 1)) begin
						ix_q    <= 2'd0;
						state_q <= ST_DIVI;
					end else cnt_q <= cnt_q + 1'b1;
				end
				ST_DIVI: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == CNW'(FB)) begin
						if (ix_q == 2'd2) state_q <= ST_POST;
						else begin
							ix_q    <= ix_q + 2'd1;
							state_q <= ST_DIVI;
						end
					end else cnt_q <= cnt_q + 1'b1;
				end
				ST_POST: begin
					if (mode_q == MD_NORMF) begin
						mode_q  <= MD_NORMS;
						state_q <= ST_SHIFT;
					end else begin
						mode_q  <= MD_CROSS;
						ix_q    <= 2'd0;
						vi_q    <= 2'd0;
						state_q <= ST_MUL;
					end
				end
				ST_ROUND: begin
					if (mode_q == MD_CROSS) begin
						vi_q <= 2'd0;
						if (ix_q == 2'd2) begin
							mode_q <= MD_DOT;
							ix_q   <= 2'd0;
						end else ix_q <= ix_q + 2'd1;
						state_q <= ST_MUL;
					end else begin
						ix_q <= 2'd0;
						if (vi_q == 2'd2) state_q <= ST_DONE;
						else begin
							vi_q    <= vi_q + 2'd1;
							state_q <= ST_MUL;
						end
					end
				end
				ST_DONE: begin
					if (res_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					for (int i = 0; i < 3; i++) begin
						eye_q[i] <= q_eye[i*CW +: CW];
						neg_q[i] <= q_neg[i];
						mag_q[i] <= MW'(q_mag[i*(CW+1) +: (CW+1)]);
					end
				end
			end
			ST_SHIFT: begin
				if (all_zero) begin
					for (int i = 0; i < 3; i++) nv_q[i] <= '0;
				end else if (any_hi) begin
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
				end else if (all_lo) begin
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
				end else acc_q <= '0;
			end
			ST_MUL: prod_q <= op_a * op_b;
			ST_ADD: acc_q <= sub ? acc_q - AW'(prod_q) : acc_q + AW'(prod_q);
			ST_SQI: begin
				sq_n_q <= acc_q[63:0];
				sq_r_q <= '0;
				sq_b_q <= 64'h4000_0000_0000_0000;
			end
			ST_SQRT: begin
				sq_n_q <= sq_n_nx;
				sq_r_q <= sq_r_nx;
				sq_b_q <= sq_b_q >> 2;
				len_q  <= sq_r_nx[31:0];
			end
			ST_DIVI: begin
				rem_q <= 31'(num[NW-1:FB+1]);
				lo_q  <= num[FB:0];
				quo_q <= '0;
			end
			ST_DIV: begin
				rem_q <= rem_nx;
				lo_q  <= lo_q << 1;
				quo_q <= quo_nx;
				if (cnt_q == CNW'(FB)) nv_q[ix_q] <= q_signed;
			end
			ST_POST: begin
				if (mode_q == MD_NORMF) begin
					for (int i = 0; i < 3; i++) f_q[i] <= nv_q[i];
					// side direction before scaling is (-f.z, 0, f.x)
					neg_q[0] <= nv_q[2] > 0;
					mag_q[0] <= MW'(abs0);
					neg_q[1] <= 1'b0;
					mag_q[1] <= '0;
					neg_q[2] <= nv_q[0] < 0;
					mag_q[2] <= MW'(abs2);
				end else begin
					for (int i = 0; i < 3; i++) s_q[i] <= nv_q[i];
					acc_q <= '0;
				end
			end
			ST_ROUND: begin
				if (mode_q == MD_CROSS) u_q[ix_q] <= VW'(rsh);
				else tr_q[vi_q] <= tr_val;
				acc_q <= '0;
			end
			default: ;
		endcase
	end

	assign q_take    = state_q == ST_IDLE;
	assign res_valid = state_q == ST_DONE;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			s_flat[i*VW +: VW]  = s_q[i];
			u_flat[i*VW +: VW]  = u_q[i];
			f_flat[i*VW +: VW]  = f_q[i];
			tr_flat[i*CW +: CW] = tr_q[i];
		end
	end

	`LAV_ASSERT(a_div_rem, clk, arst_n, state_q == ST_DIV |-> rem_q < len_q)
	`LAV_ASSERT(a_len_nz, clk, arst_n, state_q == ST_DIVI |-> len_q != 32'd0)
endmodule
`default_nettype wire

// ===== rtl/lav_out.sv =====
// result buffer: holds one matrix and hands it out a column per word
`default_nettype none
`include "assert_macros.svh"
module lav_out #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           res_valid,
	output logic                           res_ready,
	input  logic [3*(FRAC_BITS+3)-1:0]     s_flat,
	input  logic [3*(FRAC_BITS+3)-1:0]     u_flat,
	input  logic [3*(FRAC_BITS+3)-1:0]     f_flat,
	input  logic [3*COORD_WIDTH-1:0]       tr_flat,
	output logic                           empty,
	input  logic                           pop,
	output lav_pkg::col_t                  column_index,
	output logic signed [COORD_WIDTH-1:0]  row0_value,
	output logic signed [COORD_WIDTH-1:0]  row1_value,
	output logic signed [COORD_WIDTH-1:0]  row2_value,
	output logic signed [COORD_WIDTH-1:0]  row3_value,
	output logic                           last_column
);
	localparam int CW = COORD_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam int VW = FB + 3;
	localparam logic signed [CW-1:0] ONE = {{(CW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};

	logic                  valid_q;
	lav_pkg::col_t         col_q;
	logic [3*VW-1:0]       s_q;
	logic [3*VW-1:0]       u_q;
	logic [3*VW-1:0]       f_q;
	logic [3*CW-1:0]       tr_q;
	logic                  ld;
	logic                  pop_ok;
	logic signed [VW-1:0]  sv;
	logic signed [VW-1:0]  uv;
	logic signed [VW-1:0]  fv;

	assign res_ready = !valid_q;
	assign ld        = res_valid && !valid_q;
	assign pop_ok    = pop && valid_q;

	// column pointer and buffer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			col_q   <= lav_pkg::COL_FIRST;
		end else if (ld) begin
			valid_q <= 1'b1;
			col_q   <= lav_pkg::COL_FIRST;
		end else if (pop_ok) begin
			if (col_q == lav_pkg::COL_LAST) valid_q <= 1'b0;
			else col_q <= col_q + 1'b1;
		end
	end

	// matrix copy
	always_ff @(posedge clk) begin
		if (ld) begin
			s_q  <= s_flat;
			u_q  <= u_flat;
			f_q  <= f_flat;
			tr_q <= tr_flat;
		end
	end

	// column select
	always_comb begin
		sv = $signed(s_q[col_q*VW +: VW]);
		uv = $signed(u_q[col_q*VW +: VW]);
		fv = $signed(f_q[col_q*VW +: VW]);
		if (col_q == lav_pkg::COL_LAST) begin
			row0_value = $signed(tr_q[0 +: CW]);
			row1_value = $signed(tr_q[CW +: CW]);
			row2_value = $signed(tr_q[2*CW +: CW]);
			row3_value = ONE;
		end else begin
			row0_value = CW'(sv);
			row1_value = CW'(uv);
			row2_value = CW'(-fv);
			row3_value = '0;
		end
	end

	assign empty        = !valid_q;
	assign column_index = col_q;
	assign last_column  = col_q == lav_pkg::COL_LAST;

	`LAV_ASSERT(a_load_shows, clk, arst_n, ld |=> !empty && column_index == lav_pkg::COL_FIRST)
endmodule
`default_nettype wire

// ===== rtl/look_at_view_matrix.sv =====
// top level of the right-handed look-at view matrix block
//
//  channel | side   | handshake        | word
//  --------+--------+------------------+--------------------------------------
//  input   | in     | push / full      | eye_x..z, target_x..z
//  result  | out    | pop / empty      | column_index, row0..3_value, last_column
//
// one input word yields four result words, columns 0 to 3 in order
// the back end takes one item at a time, its pace set by the single shared
// multiplier, the one-bit-per-cycle square root and the restoring divider; a
// two-word job queue and a one-matrix result buffer let the input side and the
// result side stall independently
// asynchronous active-low reset clears all control state; nothing to sweep
`default_nettype none
module look_at_view_matrix #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic signed [COORD_WIDTH-1:0]  eye_x,
	input  logic signed [COORD_WIDTH-1:0]  eye_y,
	input  logic signed [COORD_WIDTH-1:0]  eye_z,
	input  logic signed [COORD_WIDTH-1:0]  target_x,
	input  logic signed [COORD_WIDTH-1:0]  target_y,
	input  logic signed [COORD_WIDTH-1:0]  target_z,
	output logic                           empty,
	input  logic                           pop,
	output lav_pkg::col_t                  column_index,
	output logic signed [COORD_WIDTH-1:0]  row0_value,
	output logic signed [COORD_WIDTH-1:0]  row1_value,
	output logic signed [COORD_WIDTH-1:0]  row2_value,
	output logic signed [COORD_WIDTH-1:0]  row3_value,
	output logic                           last_column
);
	localparam int CW = COORD_WIDTH;
	localparam int VW = FRAC_BITS + 3;

	logic                  q_valid;
	logic                  q_take;
	logic [3*CW-1:0]       q_eye;
	logic [2:0]            q_neg;
	logic [3*(CW+1)-1:0]   q_mag;
	logic                  res_valid;
	logic                  res_ready;
	logic [3*VW-1:0]       s_flat;
	logic [3*VW-1:0]       u_flat;
	logic [3*VW-1:0]       f_flat;
	logic [3*CW-1:0]       tr_flat;

	// front end and job queue
	lav_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.in_eye  ({eye_z, eye_y, eye_x}),
		.in_tgt  ({target_z, target_y, target_x}),
		.q_valid (q_valid),
		.q_take  (q_take),
		.q_eye   (q_eye),
		.q_neg   (q_neg),
		.q_mag   (q_mag)
	);

	// matrix engine
	lav_engine #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_take    (q_take),
		.q_eye     (q_eye),
		.q_neg     (q_neg),
		.q_mag     (q_mag),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.s_flat    (s_flat),
		.u_flat    (u_flat),
		.f_flat    (f_flat),
		.tr_flat   (tr_flat)
	);

	// result buffer
	lav_out #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.s_flat       (s_flat),
		.u_flat       (u_flat),
		.f_flat       (f_flat),
		.tr_flat      (tr_flat),
		.empty        (empty),
		.pop          (pop),
		.column_index (column_index),
		.row0_value   (row0_value),
		.row1_value   (row1_value),
		.row2_value   (row2_value),
		.row3_value   (row3_value),
		.last_column  (last_column)
	);
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// self-checking testbench for the look-at view matrix block
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	localparam int CW = 32;
	localparam int FB = 16;
	localparam longint ONE = 64'sd1 <<< FB;
	localparam longint QMAX = (64'sd1 <<< (CW - 1)) - 1;
	localparam longint QMIN = -(64'sd1 <<< (CW - 1));
	localparam int N_RANDOM = 190;
	localparam int PAUSE_AT = 120;
	localparam int HOLDOFF_AT = 40;
	localparam int HOLDOFF_LEN = 3000;

	typedef struct {
		logic signed [CW-1:0] ex, ey, ez, tx, ty, tz;
	} view_word_t;

	typedef struct {
		lav_pkg::col_t col;
		logic signed [CW-1:0] r0, r1, r2, r3;
		logic last;
	} column_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	logic signed [CW-1:0] eye_x = '0, eye_y = '0, eye_z = '0;
	logic signed [CW-1:0] target_x = '0, target_y = '0, target_z = '0;
	lav_pkg::col_t column_index;
	logic signed [CW-1:0] row0_value, row1_value, row2_value, row3_value;
	logic last_column;

	view_word_t pending_views[$];
	column_word_t expected_cols[$];
	int n_accepted = 0;
	int n_columns = 0;
	int n_errors = 0;
	int holdoff_left = 0;
	bit holdoff_used = 1'b0;

	look_at_view_matrix #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
		.target_x(target_x), .target_y(target_y), .target_z(target_z),
		.empty(empty), .pop(pop), .column_index(column_index),
		.row0_value(row0_value), .row1_value(row1_value),
		.row2_value(row2_value), .row3_value(row3_value),
		.last_column(last_column)
	);

	always #6 clk = ~clk;

	// bitwise integer square root, floor
	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// block-shift magnitudes into range, then divide by the floor length, rounded
	function automatic void unit_vec(input bit neg[3], input longint unsigned mag[3],
			output longint v[3]);
		longint unsigned a[3], m, sum, len, q;
		m = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = mag[i];
			if (a[i] > m) m = a[i];
		end
		if (m == 0) begin
			v = '{0, 0, 0};
			return;
		end
		while (m >= (64'd1 << 30)) begin
			m = m >> 1;
			for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
		end
		while (m < (64'd1 << 29)) begin
			m = m << 1;
			for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
		end
		sum = 0;
		for (int i = 0; i < 3; i++) sum = sum + a[i] * a[i];
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((a[i] << FB) + len / 2) / len;
			v[i] = neg[i] ? -longint'(q) : longint'(q);
		end
	endfunction

	// rounded half up, floor toward minus infinity
	function automatic longint rnd_q(input longint x);
		return (x + (64'sd1 <<< (FB - 1))) >>> FB;
	endfunction

	// translation term: rounded dot product, saturated
	function automatic longint dot_sat(input longint v[3], input longint e[3], input bit negate);
		longint acc;
		acc = v[0] * e[0] + v[1] * e[1] + v[2] * e[2];
		if (negate) acc = -acc;
		acc = rnd_q(acc);
		if (acc > QMAX) return QMAX;
		if (acc < QMIN) return QMIN;
		return acc;
	endfunction

	// build the four expected columns of one view
	function automatic void predict_matrix(input view_word_t w);
		longint eye[3], tgt[3], f[3], s0[3], s[3], u[3], tr[3];
		bit neg[3];
		longint unsigned mag[3];
		column_word_t c;
		eye = '{w.ex, w.ey, w.ez};
		tgt = '{w.tx, w.ty, w.tz};
		for (int i = 0; i < 3; i++) begin
			neg[i] = tgt[i] < eye[i];
			mag[i] = neg[i] ? longint'(eye[i] - tgt[i]) : longint'(tgt[i] - eye[i]);
		end
		unit_vec(neg, mag, f);
		// forward cross fixed up (0,1,0)
		s0[0] = rnd_q(-f[2] * ONE);
		s0[1] = 0;
		s0[2] = rnd_q(f[0] * ONE);
		for (int i = 0; i < 3; i++) begin
			neg[i] = s0[i] < 0;
			mag[i] = s0[i] < 0 ? -s0[i] : s0[i];
		end
		unit_vec(neg, mag, s);
		u[0] = rnd_q(s[1] * f[2] - s[2] * f[1]);
		u[1] = rnd_q(s[2] * f[0] - s[0] * f[2]);
		u[2] = rnd_q(s[0] * f[1] - s[1] * f[0]);
		tr[0] = dot_sat(s, eye, 1'b1);
		tr[1] = dot_sat(u, eye, 1'b1);
		tr[2] = dot_sat(f, eye, 1'b0);
		for (int k = 0; k < 4; k++) begin
			c.col = lav_pkg::col_t'(k);
			c.last = (c.col == lav_pkg::COL_LAST);
			if (k < 3) begin
				c.r0 = s[k][CW-1:0];
				c.r1 = u[k][CW-1:0];
				c.r2 = (-f[k]) & QMAX | ((-f[k]) & (64'sd1 <<< (CW - 1)));
				c.r3 = '0;
			end else begin
				c.r0 = tr[0][CW-1:0];
				c.r1 = tr[1][CW-1:0];
				c.r2 = tr[2][CW-1:0];
				c.r3 = ONE[CW-1:0];
			end
			expected_cols.push_back(c);
		end
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch col %0d %s: got %0d want %0d", n_columns, what, got, want);
		n_errors++;
	endtask

	task automatic add_view(input longint ex, ey, ez, tx, ty, tz);
		view_word_t w;
		w.ex = ex[CW-1:0]; w.ey = ey[CW-1:0]; w.ez = ez[CW-1:0];
		w.tx = tx[CW-1:0]; w.ty = ty[CW-1:0]; w.tz = tz[CW-1:0];
		pending_views.push_back(w);
	endtask

	function automatic longint rand_coord(input int mode);
		case (mode)
			0: return longint'($signed($urandom));
			1: return longint'($urandom_range(2097152)) - 1048576;
			default: return longint'($urandom_range(131072)) - 65536;
		endcase
	endfunction

	// sender idle percent, receiver idle percent by phase
	function automatic int tx_idle_pct();
		if (n_accepted < 70) return 9;
		if (n_accepted < 140) return 75;
		return 0;
	endfunction

	function automatic int rx_idle_pct();
		if (n_accepted < 70) return 75;
		if (n_accepted < 140) return 9;
		return 0;
	endfunction

	// driver: offer pending words
	always @(posedge clk) begin
		view_word_t w;
		bit go;
		if (arst_n && push && !full) begin
			predict_matrix(pending_views.pop_front());
			n_accepted++;
		end
		go = arst_n && pending_views.size() != 0 && $urandom_range(99) >= tx_idle_pct()
			&& !(n_accepted == PAUSE_AT && expected_cols.size() != 0);
		if (go) begin
			w = pending_views[0];
			eye_x <= w.ex; eye_y <= w.ey; eye_z <= w.ez;
			target_x <= w.tx; target_y <= w.ty; target_z <= w.tz;
		end
		push <= go;
	end

	// long receiver hold-off so the block backs up
	always @(posedge clk) begin
		if (holdoff_left > 0)
			holdoff_left <= holdoff_left - 1;
		else if (!holdoff_used && n_columns == HOLDOFF_AT) begin
			holdoff_left <= HOLDOFF_LEN;
			holdoff_used <= 1'b1;
		end
	end

	// monitor: check each popped column word
	always @(posedge clk) begin
		column_word_t c;
		if (arst_n && pop && !empty) begin
			if (expected_cols.size() == 0) begin
				report_mismatch("unexpected word", column_index, -1);
			end else begin
				c = expected_cols.pop_front();
				if (column_index !== c.col) report_mismatch("column_index", column_index, c.col);
				if (row0_value !== c.r0) report_mismatch("row0", row0_value, c.r0);
				if (row1_value !== c.r1) report_mismatch("row1", row1_value, c.r1);
				if (row2_value !== c.r2) report_mismatch("row2", row2_value, c.r2);
				if (row3_value !== c.r3) report_mismatch("row3", row3_value, c.r3);
				if (last_column !== c.last) report_mismatch("last_column", last_column, c.last);
			end
			n_columns++;
		end
		pop <= arst_n && holdoff_left == 0 && !(!holdoff_used && n_columns == HOLDOFF_AT)
			&& $urandom_range(99) >= rx_idle_pct();
	end

	// stimulus and end of run
	initial begin
		longint e0, e1, e2;
		int mode;
		// eye equals target
		add_view(0, 0, 0, 0, 0, 0);
		add_view(QMAX, QMAX, QMAX, QMAX, QMAX, QMAX);
		add_view(QMIN, 5 * ONE, -3, QMIN, 5 * ONE, -3);
		// forward parallel to up, both ways
		add_view(ONE, 0, 2 * ONE, ONE, 10 * ONE, 2 * ONE);
		add_view(-7 * ONE, QMAX, 3, -7 * ONE, QMIN, 3);
		// full-range differences
		add_view(QMIN, QMIN, QMIN, QMAX, QMAX, QMAX);
		add_view(QMAX, QMAX, QMAX, QMIN, QMIN, QMIN);
		add_view(QMIN, 0, QMAX, QMAX, 0, QMIN);
		// translation saturation both ways
		add_view(QMAX, QMAX, QMAX, 0, 0, 0);
		add_view(QMIN, QMIN, QMIN, 0, 0, 0);
		add_view(QMAX, QMIN, QMAX, QMIN, QMAX, QMIN);
		// ordinary camera setups, then eye equal to target once more
		add_view(0, 0, 5 * ONE, 0, 0, 0);
		add_view(3 * ONE, 2 * ONE, -4 * ONE, ONE, -ONE, ONE / 2);
		add_view(1, -1, 1, -1, 1, -1);
		add_view(-1, -1, -1, -1, -1, -1);
		for (int n = 0; n < N_RANDOM; n++) begin
			mode = $urandom_range(2);
			e0 = rand_coord(mode); e1 = rand_coord(mode); e2 = rand_coord(mode);
			case ($urandom_range(9))
				0: add_view(e0, e1, e2, e0, e1, e2);
				1: add_view(e0, e1, e2, e0, rand_coord(mode), e2);
				default: add_view(e0, e1, e2, rand_coord(mode), rand_coord(mode),
					rand_coord(mode));
			endcase
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_views.size() == 0 && !push && expected_cols.size() == 0);
		repeat (400) @(posedge clk);
		if (n_errors == 0 && expected_cols.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// run limit
	initial begin
		#(12 * 800000);
		$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire

// ===== look_at_view_matrix.f =====
+incdir+rtl
rtl/lav_pkg.sv
rtl/lav_front.sv
rtl/lav_engine.sv
rtl/lav_out.sv
rtl/look_at_view_matrix.sv
bench/tb_top.sv
